[rtl/rcf_pkg.sv]
// Shared constants, register codes and CRC-32 functions for the report CRC framer.
package rcf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CrcLen  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [CrcW-1:0]  CrcPoly       = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]  CrcPreset     = 32'hFFFF_FFFF;
  localparam logic [ByteW-1:0] SeedReset     = 8'd163;
  localparam logic [ByteW-1:0] ReportIdReset = 8'd0;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SEED      = 1'b0,
    REG_REPORT_ID = 1'b1
  } cfg_reg_t;

  // Fold one byte into a reflected CRC-32, LSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // CRC state after the preset and the two implicit header bytes
  function automatic logic [CrcW-1:0] crc_header(input logic [ByteW-1:0] seed,
                                                 input logic [ByteW-1:0] rid);
    return crc_byte(crc_byte(CrcPreset, seed), rid);
  endfunction

  localparam logic [CrcW-1:0] HdrCrcReset = crc_header(SeedReset, ReportIdReset);

endpackage

[rtl/rcf_cfg.sv]
// Configuration registers and the precomputed header CRC.
module rcf_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [rcf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rcf_pkg::ByteW-1:0]    cfg_data,
  output logic [rcf_pkg::CrcW-1:0]     hdr_crc
);

  logic [rcf_pkg::ByteW-1:0] seed_byte;
  logic [rcf_pkg::ByteW-1:0] report_id;

  // Latch a register write and refold the header into the start CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_byte <= rcf_pkg::SeedReset;
      report_id <= rcf_pkg::ReportIdReset;
      hdr_crc   <= rcf_pkg::HdrCrcReset;
    end else if (cfg_valid) begin
      unique case (rcf_pkg::cfg_reg_t'(cfg_index))
        rcf_pkg::REG_SEED: begin
          seed_byte <= cfg_data;
          hdr_crc   <= rcf_pkg::crc_header(cfg_data, report_id);
        end
        rcf_pkg::REG_REPORT_ID: begin
          report_id <= cfg_data;
          hdr_crc   <= rcf_pkg::crc_header(seed_byte, cfg_data);
        end
        default: begin
          hdr_crc <= hdr_crc;
        end
      endcase
    end
  end

endmodule

[rtl/rcf_framer.sv]
// Running CRC, CRC trailer sequencer and the output register.
module rcf_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rcf_pkg::CrcW-1:0]   hdr_crc,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rcf_pkg::ByteW-1:0]  data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rcf_pkg::ByteW-1:0]  out_byte,
  output logic                       is_crc,
  output logic                       frame_end
);

  logic [rcf_pkg::CrcW-1:0] running_crc;
  logic                     mid_frame;
  logic [rcf_pkg::CrcW-1:0] fin;
  logic [rcf_pkg::CntW-1:0] crc_cnt;

  logic                     advance;
  logic                     in_take;
  logic [rcf_pkg::CrcW-1:0] crc_next;

  // Output slot frees when empty or being taken; trailer bytes block new words
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && (crc_cnt == '0);
  assign in_take  = in_valid && in_ready;

  // One byte step from either the header CRC or the running CRC
  assign crc_next = rcf_pkg::crc_byte(mid_frame ? running_crc : hdr_crc, data_byte);

  // Hold state and the output register; advance on a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= rcf_pkg::CrcPreset;
      mid_frame   <= 1'b0;
      crc_cnt     <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      if (crc_cnt != '0) begin
        out_valid <= 1'b1;
        out_byte  <= fin[rcf_pkg::ByteW-1:0];
        is_crc    <= 1'b1;
        frame_end <= (crc_cnt == rcf_pkg::CntW'(1));
        fin       <= fin >> rcf_pkg::ByteW;
        crc_cnt   <= crc_cnt - rcf_pkg::CntW'(1);
      end else if (in_take) begin
        out_valid   <= 1'b1;
        out_byte    <= data_byte;
        is_crc      <= 1'b0;
        frame_end   <= 1'b0;
        running_crc <= crc_next;
        mid_frame   <= !last_byte;
        if (last_byte) begin
          fin     <= ~crc_next;
          crc_cnt <= rcf_pkg::CntW'(rcf_pkg::CrcLen);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // The closing word of a frame is always a CRC word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> is_crc)
    else $error("frame_end on a payload word");

  // A taken CRC word that does not close the frame is followed by another
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_crc && !frame_end |=> out_valid && is_crc)
    else $error("CRC trailer broken");

  // A last payload word arms the full four-word trailer
  assert property (@(posedge clk) disable iff (rst)
    in_take && last_byte |=> out_valid && !is_crc &&
                             crc_cnt == rcf_pkg::CntW'(rcf_pkg::CrcLen) && !mid_frame)
    else $error("trailer not armed after last word");

  // No frame is open while the trailer drains
  assert property (@(posedge clk) disable iff (rst)
    crc_cnt != '0 |-> !mid_frame)
    else $error("frame open during trailer");

endmodule

[rtl/report_crc32_framer.sv]
// Top level of the report CRC-32 framer.
// Usage:
//   Input channel (in_valid/in_ready) takes at most one payload word per cycle:
//   data_byte and last_byte. Each word comes out unchanged on the output
//   channel (out_valid/out_ready) with is_crc low. After a word with
//   last_byte set, four CRC words follow, least significant byte first,
//   with is_crc high; the fourth carries frame_end.
//   The CRC is reflected CRC-32 (0xEDB88320), preset to all ones and run
//   over seed_byte and report_id before the first payload word of a frame.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 is seed_byte, index 1 is report_id. Write between frames.
// Timing:
//   An accepted word is registered and appears on the output in the next cycle.
//   Throughput is one word per cycle while out_ready is high; a last word holds
//   off input while the four CRC words go out through the single output register.
// Reset: rst (synchronous) empties the output, closes any open frame and
//   restores seed_byte = 163, report_id = 0.
// Stall: while out_ready is low with a word on the output, it holds and in_ready drops.
module report_crc32_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcf_pkg::ByteW-1:0]     data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcf_pkg::ByteW-1:0]     out_byte,
  output logic                          is_crc,
  output logic                          frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rcf_pkg::ByteW-1:0]     cfg_data
);

  logic [rcf_pkg::CrcW-1:0] hdr_crc;

  assign cfg_ready = 1'b1;

  rcf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hdr_crc   (hdr_crc)
  );

  rcf_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .hdr_crc   (hdr_crc),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_crc    (is_crc),
    .frame_end (frame_end)
  );

endmodule
